// ===== rtl/mandelbrot_escape_time_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the escape-time pixel engine
// Shorthand for clocked checks that are disabled while reset is low.
// ----------------------------------------------------------------------------
`ifndef MANDELBROT_ESCAPE_TIME_ASSERT_SVH
`define MANDELBROT_ESCAPE_TIME_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define MBE_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define MBE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/mbe_pkg.sv =====
// ----------------------------------------------------------------------------
// mbe_pkg
// Widths, register indexes, reset values and shared types of the
// escape-time pixel engine.
// ----------------------------------------------------------------------------
package mbe_pkg;

    // Field and word widths
    localparam int COORD_W    = 11;
    localparam int WORD_W     = 32;
    localparam int PROD_W     = 2 * WORD_W;
    localparam int CNT_W      = 16;
    localparam int SHADE_W    = 8;
    localparam int CFG_ADDR_W = 3;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 48;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_REAL_ORIGIN = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_IMAG_ORIGIN = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_REAL_STEP   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_IMAG_STEP   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_ITER_LIMIT  = 3'd4;

    // Reset values: -2.5, -1.7, 4/2047 and 3.4/1535 in Q4.28, limit 1024
    localparam logic signed [WORD_W-1:0] RST_REAL_ORIGIN = -32'sd671088640;
    localparam logic signed [WORD_W-1:0] RST_IMAG_ORIGIN = -32'sd456340275;
    localparam logic signed [WORD_W-1:0] RST_REAL_STEP   = 32'sd524544;
    localparam logic signed [WORD_W-1:0] RST_IMAG_STEP   = 32'sd594580;
    localparam logic [CNT_W-1:0]         RST_ITER_LIMIT  = 16'd1024;

    // Configuration register set
    typedef struct packed {
        logic signed [WORD_W-1:0] real_origin;
        logic signed [WORD_W-1:0] imag_origin;
        logic signed [WORD_W-1:0] real_step;
        logic signed [WORD_W-1:0] imag_step;
        logic [CNT_W-1:0]         iteration_limit;
    } t_cfg;

    // Engine status towards the stream wrapper
    typedef struct packed {
        logic idle;
        logic done;
    } t_core_stat;

endpackage

// ===== rtl/mbe_core.sv =====
// ----------------------------------------------------------------------------
// mbe_core
// Sequencer and datapath around one shared 32x32 signed multiplier: maps a
// pixel to c, then runs z = z*z + c with three products per iteration.
// ----------------------------------------------------------------------------
`include "mandelbrot_escape_time_assert.svh"

module mbe_core #(
    parameter int FRAC_BITS = 28
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [mbe_pkg::COORD_W-1:0]  i_column,
    input  logic [mbe_pkg::COORD_W-1:0]  i_row,
    input  mbe_pkg::t_cfg                i_cfg,
    input  logic                         i_take,
    output mbe_pkg::t_core_stat          o_stat,
    output logic [mbe_pkg::COORD_W-1:0]  o_column,
    output logic [mbe_pkg::COORD_W-1:0]  o_row,
    output logic [mbe_pkg::CNT_W-1:0]    o_count
);
    import mbe_pkg::*;

    // Sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MCR  = 4'd1;   // column * real step
    localparam logic [3:0] S_MCI  = 4'd2;   // row * imag step, take c real
    localparam logic [3:0] S_CHK  = 4'd3;   // take c imag, clear z
    localparam logic [3:0] S_RR   = 4'd4;   // zr * zr
    localparam logic [3:0] S_II   = 4'd5;   // zi * zi
    localparam logic [3:0] S_RI   = 4'd6;   // zr * zi, escape test
    localparam logic [3:0] S_UPD  = 4'd7;   // new z, count
    localparam logic [3:0] S_DONE = 4'd8;

    logic [3:0]               r_state, n_state;
    logic [CNT_W-1:0]         r_count, n_count;
    logic [CNT_W-1:0]         r_limit;
    logic [COORD_W-1:0]       r_column, r_row;
    logic signed [PROD_W-1:0] r_prod, r_rr, r_diff;
    logic signed [WORD_W-1:0] r_cr, r_ci, r_zr, r_zi;
    logic                     r_esc;

    logic signed [WORD_W-1:0] w_mul_a, w_mul_b, w_org;
    logic signed [PROD_W-1:0] w_prod, w_c_sum, w_re_sum, w_im_sum;
    logic [PROD_W:0]          w_mag, w_four;
    logic [CNT_W-1:0]         w_cnt_inc;

    // Clamp a wide signed value to the signed word
    function automatic logic signed [WORD_W-1:0] sat_word(
        input logic signed [PROD_W-1:0] v
    );
        logic [PROD_W-WORD_W:0] top;
        logic signed [WORD_W-1:0] res;
        top = v[PROD_W-1:WORD_W-1];
        if ((&top) || !(|top)) begin
            res = v[WORD_W-1:0];
        end else if (v[PROD_W-1]) begin
            res = {1'b1, {(WORD_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(WORD_W-1){1'b1}}};
        end
        return res;
    endfunction

    // Select multiplier operands for this step
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            S_MCR: begin
                w_mul_a = $signed({{(WORD_W-COORD_W){1'b0}}, r_column});
                w_mul_b = i_cfg.real_step;
            end
            S_MCI: begin
                w_mul_a = $signed({{(WORD_W-COORD_W){1'b0}}, r_row});
                w_mul_b = i_cfg.imag_step;
            end
            S_RR: begin
                w_mul_a = r_zr;
                w_mul_b = r_zr;
            end
            S_II: begin
                w_mul_a = r_zi;
                w_mul_b = r_zi;
            end
            S_RI: begin
                w_mul_a = r_zr;
                w_mul_b = r_zi;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    // c = origin + index * step
    assign w_org   = (r_state == S_MCI) ? i_cfg.real_origin : i_cfg.imag_origin;
    assign w_c_sum = r_prod + $signed({{WORD_W{w_org[WORD_W-1]}}, w_org});

    // Squared magnitude of the old z against 4.0
    assign w_mag  = ({1'b0, r_rr} >> FRAC_BITS) + ({1'b0, r_prod} >> FRAC_BITS);
    assign w_four = (PROD_W+1)'(4) << FRAC_BITS;

    // New z components before clamping
    assign w_re_sum = (r_diff >>> FRAC_BITS) + $signed({{WORD_W{r_cr[WORD_W-1]}}, r_cr});
    assign w_im_sum = (r_prod >>> (FRAC_BITS - 1))
                    + $signed({{WORD_W{r_ci[WORD_W-1]}}, r_ci});

    assign w_cnt_inc = r_count + CNT_W'(1);

    // Advance the sequencer
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        case (r_state)
            S_IDLE: begin
                if (i_start) n_state = S_MCR;
            end
            S_MCR: n_state = S_MCI;
            S_MCI: n_state = S_CHK;
            S_CHK: begin
                n_count = '0;
                n_state = (r_limit == '0) ? S_DONE : S_RR;
            end
            S_RR: n_state = S_II;
            S_II: n_state = S_RI;
            S_RI: n_state = S_UPD;
            S_UPD: begin
                if (r_esc) begin
                    n_state = S_DONE;
                end else begin
                    n_count = w_cnt_inc;
                    n_state = (w_cnt_inc == r_limit) ? S_DONE : S_RR;
                end
            end
            S_DONE: begin
                if (i_take) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        if (r_state == S_IDLE && i_start) begin
            r_column <= i_column;
            r_row    <= i_row;
            r_limit  <= i_cfg.iteration_limit;
        end
        case (r_state)
            S_MCI: r_cr <= sat_word(w_c_sum);
            S_CHK: begin
                r_ci <= sat_word(w_c_sum);
                r_zr <= '0;
                r_zi <= '0;
            end
            S_II: r_rr <= r_prod;
            S_RI: begin
                r_diff <= r_rr - r_prod;
                r_esc  <= (w_mag >= w_four);
            end
            S_UPD: begin
                if (!r_esc) begin
                    r_zr <= sat_word(w_re_sum);
                    r_zi <= sat_word(w_im_sum);
                end
            end
            default: ;
        endcase
    end

    assign o_stat.idle = (r_state == S_IDLE);
    assign o_stat.done = (r_state == S_DONE);
    assign o_column    = r_column;
    assign o_row       = r_row;
    assign o_count     = r_count;

    // Checks
    `MBE_ASSERT_SAME(a_cnt_below_limit, r_state == S_UPD, r_count < r_limit,
        "iteration count reached limit inside the loop")
    `MBE_ASSERT_NEXT(a_escape_ends, (r_state == S_UPD) && r_esc,
        (r_state == S_DONE) && $stable(r_count), "escape did not end the pixel")
    `MBE_ASSERT_NEXT(a_cnt_step, (r_state == S_UPD) && !r_esc,
        r_count == $past(r_count) + CNT_W'(1), "count did not advance by one")
    `MBE_ASSERT_NEXT(a_done_hold, (r_state == S_DONE) && !i_take,
        (r_state == S_DONE) && $stable(r_count), "result dropped before taken")

endmodule

// ===== rtl/mandelbrot_escape_time.sv =====
// ----------------------------------------------------------------------------
// mandelbrot_escape_time
// Escape-time pixel engine: one pixel coordinate in, its iteration count
// and gray shade out, with the coordinate echoed.
// ----------------------------------------------------------------------------
// One pixel is worked at a time. A single 32x32 signed multiplier is time
// shared: the states S_MCR, S_MCI and S_CHK map the coordinate to c, then
// each iteration of z = z*z + c steps through zr*zr, zi*zi, zr*zi and the
// update. The escape test sits inside that loop, so a pixel that escapes
// runs one more pass, the one that finds it, with no update, before its
// result is handed over to a free output register.
// s_axis_tready is high only while the engine is free; a finished result
// sits in the output register, so the next pixel is taken while it waits.
// Arithmetic is signed Q4.28 (FRAC_BITS fraction bits), products floored
// and each new z component clamped to the signed 32-bit range.
`include "mandelbrot_escape_time_assert.svh"

module mandelbrot_escape_time #(
    parameter int FRAC_BITS = 28
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration write port
    input  logic                              i_cfg_we,
    input  logic [mbe_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [mbe_pkg::WORD_W-1:0]        i_cfg_data,
    // Pixel coordinates in
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [10:0] column, [21:11] row, [23:22] zero
    input  logic [mbe_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // Results out
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [10:0] pixel_column, [21:11] pixel_row, [37:22] iteration_count,
    // [45:38] shade, [47:46] zero
    output logic [mbe_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
    import mbe_pkg::*;

    localparam int PAD_W = OUT_DATA_W - 2*COORD_W - CNT_W - SHADE_W;

    t_cfg                  r_cfg;
    t_core_stat            w_stat;
    logic                  w_start, w_load;
    logic [COORD_W-1:0]    w_column, w_row;
    logic [CNT_W-1:0]      w_count;
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.real_origin     <= RST_REAL_ORIGIN;
            r_cfg.imag_origin     <= RST_IMAG_ORIGIN;
            r_cfg.real_step       <= RST_REAL_STEP;
            r_cfg.imag_step       <= RST_IMAG_STEP;
            r_cfg.iteration_limit <= RST_ITER_LIMIT;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_REAL_ORIGIN: r_cfg.real_origin     <= $signed(i_cfg_data);
                CFG_IMAG_ORIGIN: r_cfg.imag_origin     <= $signed(i_cfg_data);
                CFG_REAL_STEP:   r_cfg.real_step       <= $signed(i_cfg_data);
                CFG_IMAG_STEP:   r_cfg.imag_step       <= $signed(i_cfg_data);
                CFG_ITER_LIMIT:  r_cfg.iteration_limit <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Take a word whenever the engine is free
    assign s_axis_tready = w_stat.idle;
    assign w_start       = s_axis_tvalid && w_stat.idle;

    mbe_core #(
        .FRAC_BITS (FRAC_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_start),
        .i_column (s_axis_tdata[COORD_W-1:0]),
        .i_row    (s_axis_tdata[2*COORD_W-1:COORD_W]),
        .i_cfg    (r_cfg),
        .i_take   (w_load),
        .o_stat   (w_stat),
        .o_column (w_column),
        .o_row    (w_row),
        .o_count  (w_count)
    );

    // Output register: load when empty or being drained
    assign w_load = w_stat.done && (!r_out_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_data <= {{PAD_W{1'b0}}, w_count[SHADE_W-1:0], w_count, w_row, w_column};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // Checks
    `MBE_ASSERT_NEXT(a_wait_full, w_stat.done && r_out_valid && !m_axis_tready,
        w_stat.done, "finished result lost while output register full")
    `MBE_ASSERT_NEXT(a_load_shows, w_load, r_out_valid,
        "loaded result not presented")

endmodule
